### hw/rtl/pbr_pkg.sv
// ----------------------------------------------------------------------------
// pbr_pkg: shared types and constants
// Controller states, command/status bundles and register indexes for the
// polynomial bisection root core.
// ----------------------------------------------------------------------------
package pbr_pkg;

  localparam int unsigned IDX_W  = 3;
  localparam int unsigned ITER_W = 7;

  // configuration register indexes
  localparam logic [2:0] REG_DEGREE    = 3'd0;
  localparam logic [2:0] REG_COEF_0    = 3'd1;
  localparam logic [2:0] REG_COEF_4    = 3'd5;
  localparam logic [2:0] REG_TOLERANCE = 3'd6;
  localparam logic [2:0] REG_ITER_LIM  = 3'd7;

  // result status codes
  localparam logic [1:0] ST_CONVERGED = 2'd0;
  localparam logic [1:0] ST_NO_SIGN   = 2'd1;
  localparam logic [1:0] ST_LIMIT     = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_HORNER, S_MUL_LO, S_MUL_HI, S_NORM, S_ACCUM,
    S_SAVE_A, S_CHECK, S_MID, S_STEP, S_EMIT
  } state_t;

  // which point the polynomial is evaluated at
  typedef enum logic [1:0] {
    PH_A, PH_B, PH_M
  } phase_t;

  typedef struct packed {
    logic       load_in;
    logic       start_eval;
    phase_t     x_sel;
    logic       mul_lo;
    logic       mul_hi;
    logic       norm;
    logic       accum;
    logic       save_fa;
    logic       mid;
    logic       step;
    logic       emit;
    logic [1:0] emit_status;
  } cmd_t;

  typedef struct packed {
    logic horner_done;
    logic sign_ok;
    logic conv;
    logic lim_hit;
    logic out_free;
  } sts_t;

endpackage

### hw/rtl/pbr_if.sv
// ----------------------------------------------------------------------------
// pbr_if: channel interfaces
// Interval input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface pbr_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] low_end;
  logic signed [31:0] high_end;
  modport source (output valid, low_end, high_end, input ready);
  modport sink (input valid, low_end, high_end, output ready);
endinterface

interface pbr_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] root_estimate;
  logic signed [63:0] value_at_root;
  logic        [6:0]  iterations_used;
  logic        [1:0]  status;
  modport source (output valid, root_estimate, value_at_root, iterations_used, status,
                  input ready);
  modport sink (input valid, root_estimate, value_at_root, iterations_used, status,
                output ready);
endinterface

interface pbr_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/polynomial_bisection_root_core.sv
// Sequence: an item evaluates the polynomial at both interval ends, then once
//   at the midpoint of each halving.
// Throughput: one item at a time; the single 32x32 multiplier, used twice per
//   Horner step, sets the pace. A new item is taken once the result is parked.
// Reset: synchronous active-low; registers return to degree 1, zero coefs,
//   tolerance 66, limit 32; no result pending.
// ----------------------------------------------------------------------------
// polynomial_bisection_root_core: bisection root finder
// Finds a root of a configured polynomial (degree up to four) inside an
// interval given in signed Q16.16, by repeated halving.
// ----------------------------------------------------------------------------
module polynomial_bisection_root_core #(
  parameter int unsigned MAX_DEGREE     = 4,
  parameter int unsigned MAX_ITERATIONS = 64
) (
  input logic     clk,
  input logic     rst_n,
  pbr_in_if.sink  in_if,
  pbr_out_if.source out_if,
  pbr_cfg_if.sink cfg_if
);

  pbr_pkg::cmd_t cmd;
  pbr_pkg::sts_t sts;

  logic [pbr_pkg::IDX_W-1:0]  degree_eff;
  logic signed [31:0]         coef [MAX_DEGREE+1];
  logic [30:0]                tolerance;
  logic [pbr_pkg::ITER_W-1:0] limit_eff;

  // config writes always take effect immediately
  assign cfg_if.ready = 1'b1;

  pbr_cfg #(
    .MAX_DEGREE    (MAX_DEGREE),
    .MAX_ITERATIONS(MAX_ITERATIONS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (cfg_if.valid),
    .wr_index  (cfg_if.index),
    .wr_data   (cfg_if.data),
    .degree_eff(degree_eff),
    .coef      (coef),
    .tolerance (tolerance),
    .limit_eff (limit_eff)
  );

  // sequencer: input transfer happens only in idle
  pbr_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_if.valid),
    .in_ready(in_if.ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  // datapath with result register; result transfer frees it
  pbr_dp #(
    .MAX_DEGREE(MAX_DEGREE)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .low_end        (in_if.low_end),
    .high_end       (in_if.high_end),
    .degree_eff     (degree_eff),
    .coef           (coef),
    .tolerance      (tolerance),
    .limit_eff      (limit_eff),
    .out_ready      (out_if.ready),
    .out_valid      (out_if.valid),
    .root_estimate  (out_if.root_estimate),
    .value_at_root  (out_if.value_at_root),
    .iterations_used(out_if.iterations_used),
    .status         (out_if.status)
  );

endmodule

### hw/rtl/pbr_cfg.sv
// ----------------------------------------------------------------------------
// pbr_cfg: configuration register file
// Degree, coefficients, tolerance and iteration limit, with clamping.
// ----------------------------------------------------------------------------
module pbr_cfg #(
  parameter int unsigned MAX_DEGREE     = 4,
  parameter int unsigned MAX_ITERATIONS = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic [2:0]                   wr_index,
  input  logic [31:0]                  wr_data,
  output logic [pbr_pkg::IDX_W-1:0]    degree_eff,
  output logic signed [31:0]           coef [MAX_DEGREE+1],
  output logic [30:0]                  tolerance,
  output logic [pbr_pkg::ITER_W-1:0]   limit_eff
);

  logic [2:0]        degree_r;
  logic signed [31:0] coef_r [MAX_DEGREE+1];
  logic [30:0]       tol_r;
  logic [6:0]        lim_r;
  logic [2:0]        coef_sel;

  assign coef_sel = wr_index - pbr_pkg::REG_COEF_0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r <= 3'd1;
      tol_r    <= 31'd66;
      lim_r    <= 7'd32;
      for (int i = 0; i <= int'(MAX_DEGREE); i++) coef_r[i] <= '0;
    end else if (wr_en) begin
      if (wr_index == pbr_pkg::REG_DEGREE) degree_r <= wr_data[2:0];
      if (wr_index == pbr_pkg::REG_TOLERANCE) tol_r <= wr_data[30:0];
      if (wr_index == pbr_pkg::REG_ITER_LIM) lim_r <= wr_data[6:0];
      for (int i = 0; i <= int'(MAX_DEGREE); i++) begin
        if (wr_index >= pbr_pkg::REG_COEF_0 && wr_index <= pbr_pkg::REG_COEF_4 &&
            coef_sel == 3'(i)) coef_r[i] <= wr_data;
      end
    end
  end

  assign degree_eff = (degree_r > 3'(MAX_DEGREE)) ? 3'(MAX_DEGREE) : degree_r;
  assign limit_eff  = (lim_r == 7'd0) ? 7'd1 :
                      (lim_r > 7'(MAX_ITERATIONS)) ? 7'(MAX_ITERATIONS) : lim_r;
  assign tolerance  = tol_r;
  assign coef       = coef_r;

endmodule

### hw/rtl/pbr_ctrl.sv
// ----------------------------------------------------------------------------
// pbr_ctrl: bisection sequencer
// Steps Horner evaluations at a, b and each midpoint, and the halving loop.
// ----------------------------------------------------------------------------
module pbr_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  pbr_pkg::sts_t   sts,
  output pbr_pkg::cmd_t   cmd
);

  pbr_pkg::state_t state_r, state_nxt;
  pbr_pkg::phase_t phase_r, phase_nxt;
  logic [1:0]      stat_r, stat_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pbr_pkg::S_IDLE;
      phase_r <= pbr_pkg::PH_A;
      stat_r  <= pbr_pkg::ST_CONVERGED;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      stat_r  <= stat_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    stat_nxt  = stat_r;
    unique case (state_r)
      pbr_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = pbr_pkg::S_START;
          phase_nxt = pbr_pkg::PH_A;
        end
      end
      pbr_pkg::S_START: state_nxt = pbr_pkg::S_HORNER;
      pbr_pkg::S_HORNER: begin
        if (!sts.horner_done) state_nxt = pbr_pkg::S_MUL_LO;
        else begin
          unique case (phase_r)
            pbr_pkg::PH_A: state_nxt = pbr_pkg::S_SAVE_A;
            pbr_pkg::PH_B: state_nxt = pbr_pkg::S_CHECK;
            default:       state_nxt = pbr_pkg::S_STEP;
          endcase
        end
      end
      pbr_pkg::S_MUL_LO: state_nxt = pbr_pkg::S_MUL_HI;
      pbr_pkg::S_MUL_HI: state_nxt = pbr_pkg::S_NORM;
      pbr_pkg::S_NORM:   state_nxt = pbr_pkg::S_ACCUM;
      pbr_pkg::S_ACCUM:  state_nxt = pbr_pkg::S_HORNER;
      pbr_pkg::S_SAVE_A: begin
        state_nxt = pbr_pkg::S_START;
        phase_nxt = pbr_pkg::PH_B;
      end
      pbr_pkg::S_CHECK: begin
        if (sts.sign_ok) state_nxt = pbr_pkg::S_MID;
        else begin
          state_nxt = pbr_pkg::S_EMIT;
          stat_nxt  = pbr_pkg::ST_NO_SIGN;
        end
      end
      pbr_pkg::S_MID: begin
        state_nxt = pbr_pkg::S_START;
        phase_nxt = pbr_pkg::PH_M;
      end
      pbr_pkg::S_STEP: begin
        if (sts.conv) begin
          state_nxt = pbr_pkg::S_EMIT;
          stat_nxt  = pbr_pkg::ST_CONVERGED;
        end else if (sts.lim_hit) begin
          state_nxt = pbr_pkg::S_EMIT;
          stat_nxt  = pbr_pkg::ST_LIMIT;
        end else state_nxt = pbr_pkg::S_MID;
      end
      pbr_pkg::S_EMIT: if (sts.out_free) state_nxt = pbr_pkg::S_IDLE;
      default: state_nxt = pbr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd             = '0;
    cmd.x_sel       = phase_r;
    cmd.emit_status = stat_r;
    in_ready        = (state_r == pbr_pkg::S_IDLE);
    unique case (state_r)
      pbr_pkg::S_IDLE:   cmd.load_in    = in_valid;
      pbr_pkg::S_START:  cmd.start_eval = 1'b1;
      pbr_pkg::S_MUL_LO: cmd.mul_lo     = 1'b1;
      pbr_pkg::S_MUL_HI: cmd.mul_hi     = 1'b1;
      pbr_pkg::S_NORM:   cmd.norm       = 1'b1;
      pbr_pkg::S_ACCUM:  cmd.accum      = 1'b1;
      pbr_pkg::S_SAVE_A: cmd.save_fa    = 1'b1;
      pbr_pkg::S_MID:    cmd.mid        = 1'b1;
      pbr_pkg::S_STEP:   cmd.step       = 1'b1;
      pbr_pkg::S_EMIT:   cmd.emit       = sts.out_free;
      default: ;
    endcase
  end

endmodule

### hw/rtl/pbr_dp.sv
// ----------------------------------------------------------------------------
// pbr_dp: bisection datapath
// Interval registers, Horner unit on one 32x32 multiplier, result register.
// ----------------------------------------------------------------------------
module pbr_dp #(
  parameter int unsigned MAX_DEGREE = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pbr_pkg::cmd_t              cmd,
  output pbr_pkg::sts_t              sts,
  input  logic signed [31:0]         low_end,
  input  logic signed [31:0]         high_end,
  input  logic [pbr_pkg::IDX_W-1:0]  degree_eff,
  input  logic signed [31:0]         coef [MAX_DEGREE+1],
  input  logic [30:0]                tolerance,
  input  logic [pbr_pkg::ITER_W-1:0] limit_eff,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic signed [31:0]         root_estimate,
  output logic signed [63:0]         value_at_root,
  output logic [6:0]                 iterations_used,
  output logic [1:0]                 status
);

  logic signed [31:0] a_r, b_r, m_r, x_r;
  logic signed [63:0] fa_r, fm_r, acc_r, prod_r;
  logic [63:0]        plo_r, phi_r;
  logic [pbr_pkg::IDX_W-1:0]  idx_r;
  logic [pbr_pkg::ITER_W-1:0] iter_r;
  logic               outv_r;
  logic signed [31:0] o_root_r;
  logic signed [63:0] o_val_r;
  logic [6:0]         o_iter_r;
  logic [1:0]         o_stat_r;

  logic [63:0] acc_mag;
  logic [31:0] x_mag;
  logic        neg;
  logic [95:0] full;
  logic [79:0] q;
  logic signed [63:0] prod_nxt;
  logic signed [64:0] sum;
  logic signed [63:0] acc_nxt;
  logic signed [32:0] mid_sum;
  logic [63:0]        f_mag;
  logic [pbr_pkg::IDX_W-1:0] idx_c;

  assign acc_mag = acc_r[63] ? (64'd0 - acc_r) : acc_r;
  assign x_mag   = x_r[31] ? (32'd0 - x_r) : x_r;
  assign neg     = acc_r[63] ^ x_r[31];

  // floor(acc*x / 2^16) from |acc|*|x|, rounding toward minus infinity for negatives
  always_comb begin
    full = {32'd0, plo_r} + {phi_r, 32'd0};
    if (neg) full = full + 96'hFFFF;
    q = full[95:16];
    if (!neg) prod_nxt = (q[79:63] != '0) ? 64'sh7FFF_FFFF_FFFF_FFFF : q[63:0];
    else prod_nxt = (q[79:63] != '0) ? 64'sh8000_0000_0000_0000 : (64'd0 - q[63:0]);
  end

  assign idx_c   = (idx_r > 3'(MAX_DEGREE)) ? 3'(MAX_DEGREE) : idx_r;
  assign sum     = {prod_r[63], prod_r} + 65'(coef[idx_c]);
  assign acc_nxt = (sum[64] != sum[63]) ?
                   (sum[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF)
                   : sum[63:0];
  assign mid_sum = {a_r[31], a_r} + {b_r[31], b_r};
  assign f_mag   = acc_r[63] ? (64'd0 - acc_r) : acc_r;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      a_r    <= low_end;
      b_r    <= high_end;
      m_r    <= '0;
      fm_r   <= '0;
      iter_r <= '0;
    end
    if (cmd.start_eval) begin
      unique case (cmd.x_sel)
        pbr_pkg::PH_A: x_r <= a_r;
        pbr_pkg::PH_B: x_r <= b_r;
        default:       x_r <= m_r;
      endcase
      acc_r <= 64'(coef[0]);
      idx_r <= 3'd1;
    end
    if (cmd.mul_lo) plo_r <= 64'(acc_mag[31:0]) * 64'(x_mag);
    if (cmd.mul_hi) phi_r <= 64'(acc_mag[63:32]) * 64'(x_mag);
    if (cmd.norm) prod_r <= prod_nxt;
    if (cmd.accum) begin
      acc_r <= acc_nxt;
      idx_r <= idx_r + 3'd1;
    end
    if (cmd.save_fa) fa_r <= acc_r;
    if (cmd.mid) m_r <= mid_sum[32:1];
    if (cmd.step) begin
      fm_r   <= acc_r;
      iter_r <= iter_r + 7'd1;
      if (sts.sign_ok) b_r <= m_r;
      else begin
        a_r  <= m_r;
        fa_r <= acc_r;
      end
    end
    if (cmd.emit) begin
      o_root_r <= m_r;
      o_val_r  <= cmd.step ? acc_r : fm_r;
      o_iter_r <= iter_r;
      o_stat_r <= cmd.emit_status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) outv_r <= 1'b0;
    else if (cmd.emit) outv_r <= 1'b1;
    else if (out_ready) outv_r <= 1'b0;
  end

  assign sts.horner_done = (idx_r > degree_eff);
  assign sts.sign_ok     = (fa_r[63] && !acc_r[63] && acc_r != '0) ||
                           (!fa_r[63] && fa_r != '0 && acc_r[63]);
  assign sts.conv        = (f_mag <= 64'(tolerance));
  assign sts.lim_hit     = ((iter_r + 7'd1) >= limit_eff);
  assign sts.out_free    = !outv_r || out_ready;

  assign out_valid       = outv_r;
  assign root_estimate   = o_root_r;
  assign value_at_root   = o_val_r;
  assign iterations_used = o_iter_r;
  assign status          = o_stat_r;

endmodule

### tb/tb_polynomial_bisection_root_core.sv
// ----------------------------------------------------------------------------
// tb_polynomial_bisection_root_core: self-checking bench for the bisection core
// Sends directed and random intervals through several polynomial setups,
// predicts each result (bit-true bisection or directed table), compares every
// result transfer field by field. Both channel sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_polynomial_bisection_root_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEG_CAP  = 4;
  localparam int unsigned ITER_CAP = 64;
  localparam int          N_RANDOM = 1500;
  localparam int          N_PHASES = 12;
  localparam longint      Q_ONE    = 64'sd65536;

  // directed setups applied ahead of a table row
  typedef enum int {
    SU_NONE, SU_LINEAR, SU_SATURATE, SU_LOOSE, SU_CUBIC
  } setup_t;

  typedef struct packed {
    logic signed [31:0] root;
    logic signed [63:0] value;
    logic        [6:0]  iters;
    logic        [1:0]  status;
  } root_result_t;

  typedef struct {
    setup_t             setup;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    bit                 typed;   // expectation written below, not predicted
    root_result_t       res;
  } dir_row_t;

  logic clk;
  logic rst_n;

  pbr_in_if  in_ch ();
  pbr_out_if out_ch ();
  pbr_cfg_if cfg_ch ();

  polynomial_bisection_root_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // shadow copy of the register file, updated on each cfg transfer
  logic [2:0]  shadow_degree;
  longint      shadow_coef [5];
  logic [30:0] shadow_tol;
  logic [6:0]  shadow_limit;

  root_result_t pending_roots[$];
  int           n_checked;
  int           n_fail;
  int           n_conv, n_nosign, n_limit;
  int           burst_left;

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // --------------------------------------------------------------------------
  // Bit-true predictor
  // --------------------------------------------------------------------------
  function automatic bit signs_differ(longint p, longint q);
    return (p < 0 && q > 0) || (p > 0 && q < 0);
  endfunction

  // Horner with floor(acc*x/2^16) saturated, then a saturated add
  function automatic longint eval_poly(longint x);
    logic signed [127:0] prod;
    logic signed [64:0]  sum;
    longint              acc, scaled;
    int                  d;
    d   = (shadow_degree > DEG_CAP) ? DEG_CAP : shadow_degree;
    acc = shadow_coef[0];
    for (int i = 1; i <= d; i++) begin
      prod = acc;
      prod = (prod * x) >>> 16;        // arithmetic shift floors
      if (prod > 128'sd9223372036854775807) scaled = 64'sh7FFF_FFFF_FFFF_FFFF;
      else if (prod < -128'sd9223372036854775808) scaled = 64'sh8000_0000_0000_0000;
      else scaled = prod[63:0];
      sum = scaled;
      sum = sum + shadow_coef[i];
      if (sum > 65'sd9223372036854775807) acc = 64'sh7FFF_FFFF_FFFF_FFFF;
      else if (sum < -65'sd9223372036854775808) acc = 64'sh8000_0000_0000_0000;
      else acc = sum[63:0];
    end
    return acc;
  endfunction

  function automatic root_result_t bisect_interval(logic signed [31:0] lo,
                                                   logic signed [31:0] hi);
    root_result_t       r;
    logic signed [32:0] s;
    longint             a, b, fa, fb, m, fm;
    logic [63:0]        mag;
    int                 lim, it;
    a   = lo;
    b   = hi;
    fa  = eval_poly(a);
    fb  = eval_poly(b);
    lim = (shadow_limit == 0) ? 1 : ((shadow_limit > ITER_CAP) ? ITER_CAP : shadow_limit);
    r   = '0;
    if (!signs_differ(fa, fb)) begin
      r.status = pbr_pkg::ST_NO_SIGN;
      return r;
    end
    it = 0;
    forever begin
      s  = $signed(a[31:0]);
      s  = s + $signed(b[31:0]);
      m  = s >>> 1;
      fm = eval_poly(m);
      it++;
      if (signs_differ(fa, fm)) b = m;
      else begin
        a  = m;
        fa = fm;
      end
      mag = (fm < 0) ? 64'(-fm) : 64'(fm);
      r.root  = m[31:0];
      r.value = fm;
      r.iters = 7'(it);
      if (mag <= 64'(shadow_tol)) begin
        r.status = pbr_pkg::ST_CONVERGED;
        return r;
      end
      if (it >= lim) begin
        r.status = pbr_pkg::ST_LIMIT;
        return r;
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Drivers (negedge) and checker (posedge)
  // --------------------------------------------------------------------------
  task automatic cfg_write(logic [2:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      pbr_pkg::REG_DEGREE:    shadow_degree = data[2:0];
      pbr_pkg::REG_TOLERANCE: shadow_tol    = data[30:0];
      pbr_pkg::REG_ITER_LIM:  shadow_limit  = data[6:0];
      default:                shadow_coef[idx - pbr_pkg::REG_COEF_0] = longint'($signed(data));
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic load_poly(logic [2:0] deg, longint c0, longint c1, longint c2,
                           longint c3, longint c4, logic [30:0] tol, logic [6:0] lim);
    longint cs [5];
    cs = '{c0, c1, c2, c3, c4};
    cfg_write(pbr_pkg::REG_DEGREE, 32'(deg));
    for (int i = 0; i < 5; i++) cfg_write(pbr_pkg::REG_COEF_0 + 3'(i), cs[i][31:0]);
    cfg_write(pbr_pkg::REG_TOLERANCE, 32'(tol));
    cfg_write(pbr_pkg::REG_ITER_LIM, 32'(lim));
  endtask

  // block is idle once every expected result has come back
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_roots.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one interval transfer; sender idles between bursts of random length
  task automatic send_interval(logic signed [31:0] lo, logic signed [31:0] hi,
                               bit typed, root_result_t typed_res);
    if (burst_left == 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 10);
    end
    @(negedge clk);
    in_ch.valid    <= 1'b1;
    in_ch.low_end  <= lo;
    in_ch.high_end <= hi;
    do @(posedge clk); while (!in_ch.ready);
    pending_roots.push_back(typed ? typed_res : bisect_interval(lo, hi));
    burst_left--;
  endtask

  // receiver stall pattern: a new random mode is drawn whenever stall_cyc[7:0] is zero
  int unsigned stall_cyc;
  int unsigned stall_mode;
  always @(negedge clk) begin
    stall_cyc <= stall_cyc + 1;
    if (stall_cyc[7:0] == 8'd0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0:       out_ch.ready <= 1'b1;
      1:       out_ch.ready <= $urandom_range(0, 1);
      2:       out_ch.ready <= (stall_cyc[3:0] < 4'd3);
      default: out_ch.ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk) begin
    root_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_roots.size() == 0) begin
        $error("result transfer with nothing expected");
        n_fail++;
      end else begin
        want = pending_roots.pop_front();
        n_checked++;
        if (out_ch.root_estimate !== want.root) begin
          $error("root_estimate expected %0d actual %0d", want.root, out_ch.root_estimate);
          n_fail++;
        end
        if (out_ch.value_at_root !== want.value) begin
          $error("value_at_root expected %0d actual %0d", want.value, out_ch.value_at_root);
          n_fail++;
        end
        if (out_ch.iterations_used !== want.iters) begin
          $error("iterations_used expected %0d actual %0d", want.iters,
                 out_ch.iterations_used);
          n_fail++;
        end
        if (out_ch.status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, out_ch.status);
          n_fail++;
        end
        case (want.status)
          pbr_pkg::ST_CONVERGED: n_conv++;
          pbr_pkg::ST_NO_SIGN:   n_nosign++;
          default:               n_limit++;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Directed table
  // --------------------------------------------------------------------------
  localparam root_result_t NO_ROOT = '{root: '0, value: '0, iters: '0,
                                       status: pbr_pkg::ST_NO_SIGN};
  localparam root_result_t NONE    = '0;

  dir_row_t dir_rows [] = '{
    // reset setup: f == 0 everywhere, so never a sign change
    '{SU_NONE,     32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1, NO_ROOT},
    '{SU_NONE,     32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1, NO_ROOT},
    '{SU_NONE,     32'sh0000_0000, 32'sh0000_0000, 1'b1, NO_ROOT},
    // f(x) = x - 1.0
    '{SU_LINEAR,   32'sh0000_0000, 32'sh0002_0000, 1'b0, NONE},
    '{SU_NONE,     32'sh0002_0000, 32'sh0000_0000, 1'b0, NONE},  // reversed ends
    '{SU_NONE,     32'sh0001_0000, 32'sh0003_0000, 1'b1, NO_ROOT}, // zero at an end
    '{SU_NONE,     32'sh0003_0000, 32'sh0003_0000, 1'b1, NO_ROOT}, // a == b
    '{SU_NONE,     32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0, NONE},
    '{SU_NONE,     32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0, NONE},
    '{SU_NONE,     32'shFFFB_0000, 32'sh0001_0001, 1'b0, NONE},
    // degree above the cap, extreme coefficients, zero limit, zero tolerance
    '{SU_SATURATE, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0, NONE},
    '{SU_NONE,     32'shFFFF_FFFF, 32'sh0000_0001, 1'b0, NONE},
    '{SU_NONE,     32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1, NO_ROOT},
    // limit above the cap, loose tolerance on a deep cubic
    '{SU_LOOSE,    32'shFFF0_0000, 32'sh0013_0000, 1'b0, NONE},
    '{SU_NONE,     32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0, NONE},
    // tight tolerance, full 64 halvings likely
    '{SU_CUBIC,    32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0, NONE},
    '{SU_NONE,     32'shFFFE_0000, 32'sh0003_8000, 1'b0, NONE},
    '{SU_NONE,     32'sh0003_8000, 32'shFFFE_0000, 1'b0, NONE}
  };

  task automatic apply_setup(setup_t su);
    if (su == SU_NONE) return;
    drain_results();
    case (su)
      SU_LINEAR:   load_poly(3'd1, Q_ONE, -Q_ONE, 0, 0, 0, 31'd66, 7'd32);
      SU_SATURATE: load_poly(3'd7, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF,
                             64'sh7FFF_FFFF, -64'sh8000_0000, 31'd0, 7'd0);
      SU_LOOSE:    load_poly(3'd3, Q_ONE, 0, -3 * Q_ONE, Q_ONE / 2, 0,
                             31'h7FFF_FFFF, 7'd127);
      default:     load_poly(3'd3, Q_ONE, -64'sh8000_0000, Q_ONE, 64'sh7FFF_FFFF, 0,
                             31'd0, 7'd64);
    endcase
  endtask

  // random coefficient: mostly a few units, now and then the full range
  function automatic longint rand_coef();
    if ($urandom_range(0, 7) == 0) return longint'($signed($urandom()));
    return longint'($signed(32'($urandom_range(0, 8 << 16)) - 32'(4 << 16)));
  endfunction

  // random interval: mostly wide and straddling zero, so odd-degree fits root
  task automatic send_random_interval();
    logic signed [31:0] lo, hi;
    int                 pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      lo = -$signed(32'($urandom_range(1, 32'h00FF_FFFF)));
      hi = $signed(32'($urandom_range(1, 32'h00FF_FFFF)));
      if ($urandom_range(0, 1)) {lo, hi} = {hi, lo};
    end else if (pick < 85) begin
      lo = $urandom();
      hi = $urandom();
    end else begin
      lo = ($urandom_range(0, 1)) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      hi = ($urandom_range(0, 2) == 0) ? lo : ($urandom_range(0, 1) ? 32'sh0 : -lo);
    end
    send_interval(lo, hi, 1'b0, NONE);
  endtask

  initial begin
    logic [2:0]  deg;
    logic [30:0] tol;
    logic [6:0]  lim;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.low_end  = '0;
    in_ch.high_end = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = pbr_pkg::REG_DEGREE;
    cfg_ch.data    = '0;
    out_ch.ready   = 1'b0;
    stall_cyc      = 0;
    stall_mode     = 0;
    burst_left     = 0;
    n_checked = 0; n_fail = 0; n_conv = 0; n_nosign = 0; n_limit = 0;
    shadow_degree  = 3'd1;
    shadow_coef    = '{0, 0, 0, 0, 0};
    shadow_tol     = 31'd66;
    shadow_limit   = 7'd32;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) begin
      apply_setup(dir_rows[i].setup);
      send_interval(dir_rows[i].lo, dir_rows[i].hi, dir_rows[i].typed, dir_rows[i].res);
    end

    // random phases: a fresh polynomial per phase, odd degree favored
    for (int p = 0; p < N_PHASES; p++) begin
      drain_results();
      case ($urandom_range(0, 9))
        0:       deg = $urandom_range(0, 7);
        1, 2:    deg = 3'd2;
        3, 4:    deg = 3'd3;
        5:       deg = 3'd4;
        default: deg = 3'd1;
      endcase
      tol = ($urandom_range(0, 5) == 0) ? 31'($urandom()) : 31'($urandom_range(0, 1 << 16));
      lim = ($urandom_range(0, 5) == 0) ? 7'($urandom_range(0, 127))
                                        : 7'($urandom_range(1, 24));
      load_poly(deg, rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                tol, lim);
      for (int k = 0; k < N_RANDOM / N_PHASES; k++) send_random_interval();
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_roots.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Checked %0d results: %0d converged, %0d without sign change, %0d at limit",
             n_checked, n_conv, n_nosign, n_limit);
    $display("Covered %0d polynomial setups plus directed extremes", N_PHASES);
    if (n_fail == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  // watchdog: far above the slowest legal run with stalls on both sides
  initial begin
    #60_000_000;
    $display("Timeout with %0d results outstanding", pending_roots.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

### sim.f
hw/rtl/pbr_pkg.sv
hw/rtl/pbr_if.sv
hw/rtl/pbr_cfg.sv
hw/rtl/pbr_ctrl.sv
hw/rtl/pbr_dp.sv
hw/rtl/polynomial_bisection_root_core.sv
tb/tb_polynomial_bisection_root_core.sv
